>>> src/sfcan_pkg.sv
// Shared types and constants for the serial frame to CAN fields block.
// No dependencies.
`timescale 1ns / 1ps

package sfcan_pkg;

   // Frame hunt phases
   typedef enum logic [1:0] {
      PHASE_HUNT_FIRST  = 2'd0,
      PHASE_HUNT_SECOND = 2'd1,
      PHASE_BODY        = 2'd2
   } phase_type;

   localparam logic [7:0] HDR_FIRST  = 8'hAA;
   localparam logic [7:0] HDR_SECOND = 8'h55;

   // Frame byte positions
   localparam logic [3:0] POS_SECOND   = 4'd1;
   localparam logic [3:0] BODY_FIRST   = 4'd2;
   localparam logic [3:0] ID_LO_POS    = 4'd2;
   localparam logic [3:0] ID_HI_POS    = 4'd3;
   localparam logic [3:0] LEN_POS      = 4'd4;
   localparam logic [3:0] PAYLOAD_POS  = 4'd5;
   localparam logic [3:0] LAST_SUM_POS = 4'd12;
   localparam logic [3:0] SUM_LO_POS   = 4'd13;
   localparam logic [3:0] SUM_HI_POS   = 4'd14;
   localparam logic [3:0] FRAME_LAST   = 4'd15;

   // Sum of the two header bytes, the start of the running checksum
   localparam logic [15:0] SUM_INIT = 16'h00FF;

endpackage

>>> src/serial_frame_to_can_fields.sv
// Serial frame to CAN fields: header hunt, frame capture, checksum, result register.
// Depends on sfcan_pkg.
`timescale 1ns / 1ps

// Takes one received serial byte per cycle and hunts for the header 0xAA 0x55
// (a repeated 0xAA restarts the hunt), then captures the rest of a 16-byte
// frame. A running 16-bit sum of frame bytes 0..12 is kept as bytes arrive, so
// at the last byte the check against bytes 13 (low) and 14 (high) is a single
// compare. A good frame yields one word with the CAN identifier (byte 3 high,
// byte 2 low), the length code (byte 4) and payload bytes 5..12; a bad frame
// is dropped without notice and the footer is not checked. A byte is accepted
// in every cycle except while a finished word sits in the output register and
// rsp_ready is low. The result is registered and appears in the cycle after the
// last frame byte is accepted.
module serial_frame_to_can_fields (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_can_id,
   output logic [7:0]  rsp_data_length,
   output logic [7:0]  rsp_payload_0,
   output logic [7:0]  rsp_payload_1,
   output logic [7:0]  rsp_payload_2,
   output logic [7:0]  rsp_payload_3,
   output logic [7:0]  rsp_payload_4,
   output logic [7:0]  rsp_payload_5,
   output logic [7:0]  rsp_payload_6,
   output logic [7:0]  rsp_payload_7
);

   sfcan_pkg::phase_type phase_ff, phase_in;
   logic [3:0]  pos_ff, pos_in;
   logic [15:0] sum_ff, sum_in;
   logic [7:0]  store_ff [sfcan_pkg::BODY_FIRST:sfcan_pkg::SUM_HI_POS];

   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] can_id_ff;
   logic [7:0]  length_ff;
   logic [7:0]  payload_ff [8];

   logic        accept;
   logic        in_body;
   logic        store_we;
   logic        frame_end;
   logic        sum_ok;
   logic        rsp_load;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Next state of the header hunt and the byte position
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      if (accept) begin
         unique case (phase_ff)
            sfcan_pkg::PHASE_HUNT_FIRST: begin
               if (req_rx_byte == sfcan_pkg::HDR_FIRST) begin
                  phase_in = sfcan_pkg::PHASE_HUNT_SECOND;
                  pos_in   = sfcan_pkg::POS_SECOND;
               end
            end
            sfcan_pkg::PHASE_HUNT_SECOND: begin
               priority if (req_rx_byte == sfcan_pkg::HDR_SECOND) begin
                  phase_in = sfcan_pkg::PHASE_BODY;
                  pos_in   = sfcan_pkg::BODY_FIRST;
               end else if (req_rx_byte == sfcan_pkg::HDR_FIRST) begin
                  phase_in = sfcan_pkg::PHASE_HUNT_SECOND;
                  pos_in   = sfcan_pkg::POS_SECOND;
               end else begin
                  phase_in = sfcan_pkg::PHASE_HUNT_FIRST;
                  pos_in   = '0;
               end
            end
            sfcan_pkg::PHASE_BODY: begin
               if (pos_ff == sfcan_pkg::FRAME_LAST) begin
                  phase_in = sfcan_pkg::PHASE_HUNT_FIRST;
                  pos_in   = '0;
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end
            default: begin
               phase_in = sfcan_pkg::PHASE_HUNT_FIRST;
               pos_in   = '0;
            end
         endcase
      end
   end

   // Datapath controls: capture, running sum, checksum check, result valid
   always_comb begin
      in_body   = accept && (phase_ff == sfcan_pkg::PHASE_BODY);
      store_we  = in_body && (pos_ff != sfcan_pkg::FRAME_LAST);
      frame_end = in_body && (pos_ff == sfcan_pkg::FRAME_LAST);
      sum_in    = sum_ff;
      if (accept && phase_ff == sfcan_pkg::PHASE_HUNT_SECOND
          && req_rx_byte == sfcan_pkg::HDR_SECOND) begin
         sum_in = sfcan_pkg::SUM_INIT;
      end else if (in_body && pos_ff <= sfcan_pkg::LAST_SUM_POS) begin
         sum_in = sum_ff + {8'd0, req_rx_byte};
      end
      sum_ok = (sum_ff[7:0] == store_ff[sfcan_pkg::SUM_LO_POS])
            && (sum_ff[15:8] == store_ff[sfcan_pkg::SUM_HI_POS]);
      rsp_load = frame_end && sum_ok;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= sfcan_pkg::PHASE_HUNT_FIRST;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (store_we) begin
         store_ff[pos_ff] <= req_rx_byte;
      end
      if (rsp_load) begin
         can_id_ff <= {store_ff[sfcan_pkg::ID_HI_POS], store_ff[sfcan_pkg::ID_LO_POS]};
         length_ff <= store_ff[sfcan_pkg::LEN_POS];
         for (int i = 0; i < 8; i++) begin
            payload_ff[i] <= store_ff[sfcan_pkg::PAYLOAD_POS + 4'(i)];
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_can_id      = can_id_ff;
   assign rsp_data_length = length_ff;
   assign rsp_payload_0   = payload_ff[0];
   assign rsp_payload_1   = payload_ff[1];
   assign rsp_payload_2   = payload_ff[2];
   assign rsp_payload_3   = payload_ff[3];
   assign rsp_payload_4   = payload_ff[4];
   assign rsp_payload_5   = payload_ff[5];
   assign rsp_payload_6   = payload_ff[6];
   assign rsp_payload_7   = payload_ff[7];

   // A word is produced only at the last byte of a frame body
   a_load_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (phase_ff == sfcan_pkg::PHASE_BODY && pos_ff == sfcan_pkg::FRAME_LAST))
      else $error("result loaded outside frame end");

   // Body positions never fall back into the header
   a_body_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sfcan_pkg::PHASE_BODY |-> pos_ff >= sfcan_pkg::BODY_FIRST)
      else $error("body position below first body byte");

   // Waiting for the second header byte always means one byte captured
   a_hunt_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == sfcan_pkg::PHASE_HUNT_SECOND |-> pos_ff == sfcan_pkg::POS_SECOND)
      else $error("position out of step with header hunt");

   // A finished frame returns the hunt to the first header byte
   a_restart: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> (phase_ff == sfcan_pkg::PHASE_HUNT_FIRST && pos_ff == 4'd0))
      else $error("hunt did not restart after frame end");

endmodule

>>> bench/serial_frame_to_can_fields_tb.sv
// Self-checking testbench for serial_frame_to_can_fields: directed and random byte
// streams, predicted frame results, random idling and a long receiver hold-off.
// Depends on sfcan_pkg and the serial_frame_to_can_fields RTL.
`timescale 1ns / 1ps

module serial_frame_to_can_fields_tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 300;
   localparam int MAX_REPORTS    = 10;
   localparam int FRAME_BYTES    = 16;

   typedef logic [7:0] frame_type [16];

   typedef struct packed {
      logic [15:0]     can_id;
      logic [7:0]      data_length;
      logic [7:0][7:0] payload;
   } can_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_can_id;
   logic [7:0]  rsp_data_length;
   logic [7:0]  rsp_payload_0, rsp_payload_1, rsp_payload_2, rsp_payload_3;
   logic [7:0]  rsp_payload_4, rsp_payload_5, rsp_payload_6, rsp_payload_7;

   serial_frame_to_can_fields i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_can_id      (rsp_can_id),
      .rsp_data_length (rsp_data_length),
      .rsp_payload_0   (rsp_payload_0),
      .rsp_payload_1   (rsp_payload_1),
      .rsp_payload_2   (rsp_payload_2),
      .rsp_payload_3   (rsp_payload_3),
      .rsp_payload_4   (rsp_payload_4),
      .rsp_payload_5   (rsp_payload_5),
      .rsp_payload_6   (rsp_payload_6),
      .rsp_payload_7   (rsp_payload_7)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_asked    = 0;
   int bytes_sent    = 0;
   int mismatch_count = 0;

   can_word_type pending_words[$];

   // frame tracker state
   sfcan_pkg::phase_type hunt = sfcan_pkg::PHASE_HUNT_FIRST;
   logic [4:0] next_pos = '0;
   logic [7:0] frame_bytes [16];

   function automatic void track_byte(input logic [7:0] b);
      logic [15:0]  sum;
      can_word_type w;
      unique case (hunt)
         sfcan_pkg::PHASE_HUNT_FIRST: begin
            if (b == sfcan_pkg::HDR_FIRST) begin
               frame_bytes[0] = b;
               next_pos = 5'd1;
               hunt = sfcan_pkg::PHASE_HUNT_SECOND;
            end
         end
         sfcan_pkg::PHASE_HUNT_SECOND: begin
            if (b == sfcan_pkg::HDR_SECOND) begin
               frame_bytes[sfcan_pkg::POS_SECOND] = b;
               next_pos = 5'(sfcan_pkg::BODY_FIRST);
               hunt = sfcan_pkg::PHASE_BODY;
            end else if (b == sfcan_pkg::HDR_FIRST) begin
               next_pos = 5'd1;
            end else begin
               next_pos = '0;
               hunt = sfcan_pkg::PHASE_HUNT_FIRST;
            end
         end
         sfcan_pkg::PHASE_BODY: begin
            frame_bytes[next_pos[3:0]] = b;
            next_pos = next_pos + 5'd1;
            if (next_pos >= FRAME_BYTES) begin
               next_pos = '0;
               hunt = sfcan_pkg::PHASE_HUNT_FIRST;
               sum = '0;
               for (int k = 0; k <= sfcan_pkg::LAST_SUM_POS; k++)
                  sum += 16'(frame_bytes[k]);
               if (sum[7:0] == frame_bytes[sfcan_pkg::SUM_LO_POS]
                   && sum[15:8] == frame_bytes[sfcan_pkg::SUM_HI_POS])
               begin
                  w.can_id = {frame_bytes[sfcan_pkg::ID_HI_POS],
                              frame_bytes[sfcan_pkg::ID_LO_POS]};
                  w.data_length = frame_bytes[sfcan_pkg::LEN_POS];
                  for (int j = 0; j < 8; j++)
                     w.payload[j] = frame_bytes[sfcan_pkg::PAYLOAD_POS + j];
                  pending_words.push_back(w);
               end
            end
         end
         default: begin
            next_pos = '0;
            hunt = sfcan_pkg::PHASE_HUNT_FIRST;
         end
      endcase
   endfunction

   function automatic frame_type make_frame(input logic [15:0] id, input logic [7:0] len,
                                            input logic [7:0][7:0] pl,
                                            input logic [7:0] footer);
      frame_type   f;
      logic [15:0] sum;
      f[0] = sfcan_pkg::HDR_FIRST;
      f[sfcan_pkg::POS_SECOND] = sfcan_pkg::HDR_SECOND;
      f[sfcan_pkg::ID_LO_POS] = id[7:0];
      f[sfcan_pkg::ID_HI_POS] = id[15:8];
      f[sfcan_pkg::LEN_POS] = len;
      for (int j = 0; j < 8; j++) f[sfcan_pkg::PAYLOAD_POS + j] = pl[j];
      sum = '0;
      for (int k = 0; k <= sfcan_pkg::LAST_SUM_POS; k++) sum += 16'(f[k]);
      f[sfcan_pkg::SUM_LO_POS] = sum[7:0];
      f[sfcan_pkg::SUM_HI_POS] = sum[15:8];
      f[sfcan_pkg::FRAME_LAST] = footer;
      return f;
   endfunction

   // Valid stays high between back-to-back bytes; it drops only during a gap.
   task automatic send_byte(input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      track_byte(b);
      bytes_sent++;
   endtask

   task automatic send_frame(input frame_type f, input int count);
      for (int k = 0; k < count; k++) send_byte(f[k]);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      can_word_type want;
      can_word_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.can_id = rsp_can_id;
         got.data_length = rsp_data_length;
         got.payload = {rsp_payload_7, rsp_payload_6, rsp_payload_5, rsp_payload_4,
                        rsp_payload_3, rsp_payload_2, rsp_payload_1, rsp_payload_0};
         if (pending_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected word, can_id %h", $realtime, got.can_id);
         end else begin
            want = pending_words.pop_front();
            check_field("can_id", want.can_id, got.can_id);
            check_field("data_length", 16'(want.data_length), 16'(got.data_length));
            for (int j = 0; j < 8; j++)
               check_field($sformatf("payload_%0d", j), 16'(want.payload[j]),
                           16'(got.payload[j]));
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin : receiver
      int hold_done;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_done != hold_asked) begin
            hold_done++;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // watchdog: cycles with no word moving on either side
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("serial_frame_to_can_fields_tb: FAIL");
            $finish;
         end
      end
   end

   // stray bytes in both hunt phases, a repeated first header byte
   task automatic test_hunt_noise();
      send_byte(8'h00);
      send_byte(sfcan_pkg::HDR_SECOND);
      send_byte(sfcan_pkg::HDR_FIRST);
      send_byte(8'h13);
      send_byte(sfcan_pkg::HDR_FIRST);
   endtask

   // all-ones frame, header bytes inside the body, bad and good checksums
   task automatic test_directed_frames();
      frame_type       f;
      logic [7:0][7:0] pl;
      f = make_frame(16'hFFFF, 8'hFF, {8{8'hFF}}, 8'hFF);
      send_frame(f, FRAME_BYTES);
      pl = '0;
      pl[1] = sfcan_pkg::HDR_FIRST;
      pl[2] = sfcan_pkg::HDR_SECOND;
      f = make_frame(16'h0000, 8'h00, pl, 8'h00);
      f[sfcan_pkg::SUM_LO_POS] ^= 8'h01;
      send_frame(f, FRAME_BYTES);
      f[sfcan_pkg::SUM_LO_POS] ^= 8'h01;
      send_frame(f, FRAME_BYTES);
      f[sfcan_pkg::SUM_HI_POS] ^= 8'h80;
      send_frame(f, FRAME_BYTES);
   endtask

   task automatic test_random_traffic(input int budget);
      int        stop_at;
      int        pick;
      int        noise_len;
      frame_type f;
      logic [7:0] flip;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         flip = 8'(1 << $urandom_range(7));
         f = make_frame(16'($urandom),
                        ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(8)),
                        {$urandom, $urandom}, 8'($urandom));
         if (pick < 65) begin
            if ($urandom_range(7) == 0) send_byte(sfcan_pkg::HDR_FIRST);
            send_frame(f, FRAME_BYTES);
         end else if (pick < 80) begin
            case ($urandom_range(2))
               0: f[sfcan_pkg::SUM_LO_POS] ^= flip;
               1: f[sfcan_pkg::SUM_HI_POS] ^= flip;
               default: f[$urandom_range(sfcan_pkg::BODY_FIRST, sfcan_pkg::LAST_SUM_POS)]
                           ^= flip;
            endcase
            send_frame(f, FRAME_BYTES);
         end else if (pick < 88) begin
            // cut-off frame, the next bytes land in its body
            send_frame(f, $urandom_range(3, FRAME_BYTES - 1));
         end else begin
            noise_len = $urandom_range(1, 6);
            repeat (noise_len) begin
               case ($urandom_range(5))
                  0, 1: send_byte(sfcan_pkg::HDR_FIRST);
                  2: send_byte(sfcan_pkg::HDR_SECOND);
                  default: send_byte(8'($urandom));
               endcase
            end
         end
      end
   endtask

   // receiver holds off while frames keep coming, so the input stalls
   task automatic test_backpressure();
      hold_asked++;
      repeat (3) send_frame(make_frame(16'($urandom), 8'($urandom_range(8)),
                                       {$urandom, $urandom}, 8'($urandom)), FRAME_BYTES);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 7;
      recv_idle_pct = 66;
      test_hunt_noise();
      test_directed_frames();
      test_random_traffic(195);

      send_idle_pct = 66;
      recv_idle_pct = 7;
      test_random_traffic(195);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(195);
      test_backpressure();

      wait_drained();
      if (mismatch_count == 0) begin
         $display("serial_frame_to_can_fields_tb: PASS");
      end else begin
         $display("serial_frame_to_can_fields_tb: FAIL");
      end
      $finish;
   end

endmodule
